### rtl/core/tsc_pkg.sv
package tsc_pkg;

    localparam int ANGLE_W    = 32;
    localparam int VALUE_W    = 32;
    localparam int THRESH_W   = 31;
    localparam int ANGLE_FRAC = 24;
    localparam int OUT_FRAC   = 30;

    localparam int MAX_TERMS_DEFAULT = 24;
    localparam int FRAC_BITS_DEFAULT = 30;

    // Quotient bits retired by the divider in one cycle.
    localparam int DIV_BITS = 4;

    localparam logic [THRESH_W-1:0]       THRESH_RESET = 31'd107;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q24   = 32'sd105414357;
    localparam int                        ANG_MAG_W    = $clog2(TWO_PI_Q24 + 1);

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

    typedef struct packed {
        logic load_angle;
        logic reduce_sub;
        logic reduce_add;
        logic convert;
        logic mul_x2_start;
        logic load_x2;
        logic series_init;
        logic series_cos;
        logic term_accept;
        logic div_start;
        logic term_update;
        logic save_sine;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic above;
        logic below;
        logic term_small;
        logic mul_done;
        logic div_done;
    } status_t;

endpackage

### rtl/core/tsc_angle_if.sv
interface tsc_angle_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [tsc_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);

endinterface

### rtl/core/tsc_result_if.sv
interface tsc_result_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [tsc_pkg::VALUE_W-1:0]   sine_value;
    logic signed [tsc_pkg::VALUE_W-1:0]   cosine_value;

    modport source (output valid, output sine_value, output cosine_value, input ready);
    modport sink (input valid, input sine_value, input cosine_value, output ready);

endinterface

### rtl/core/tsc_mul.sv
module tsc_mul #(
    parameter int OP_W  = 38,
    parameter int SHIFT = 30,
    parameter int RES_W = 43
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OP_W-1:0]  a,
    input  logic [OP_W-1:0]  b,
    output logic             done,
    output logic [RES_W-1:0] res
);

    localparam int H      = (OP_W + 1) / 2;
    localparam int PP_W   = 2 * H;
    localparam int ACC_W  = 4 * H;
    localparam int LAST   = 4;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (SHIFT - 1);

    logic [OP_W-1:0]  a_reg;
    logic [OP_W-1:0]  b_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [PP_W-1:0]  pp_reg;
    logic [1:0]       pp_sel_reg;
    logic             pp_valid_reg;
    logic [2:0]       step_reg;
    logic             run_reg;
    logic             done_reg;

    logic [H-1:0]     a_limb;
    logic [H-1:0]     b_limb;
    logic [1:0]       pp_pos;
    logic [ACC_W-1:0] pp_shifted;

    always_comb
    begin
        a_limb = step_reg[0] ? H'(a_reg >> H) : a_reg[H-1:0];
        b_limb = step_reg[1] ? H'(b_reg >> H) : b_reg[H-1:0];
        pp_pos = {1'b0, pp_sel_reg[0]} + {1'b0, pp_sel_reg[1]};
        unique case (pp_pos)
            2'd0:    pp_shifted = ACC_W'(pp_reg);
            2'd1:    pp_shifted = ACC_W'(pp_reg) << H;
            2'd2:    pp_shifted = ACC_W'(pp_reg) << (2 * H);
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= '0;
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == 3'(LAST));
            if (start)
            begin
                run_reg      <= 1'b1;
                step_reg     <= '0;
                pp_valid_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                step_reg     <= step_reg + 3'd1;
                pp_valid_reg <= (step_reg != 3'(LAST));
                if (step_reg == 3'(LAST))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // The accumulator starts at half an output LSB, so the final shift rounds half up.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= ROUND;
        end
        else if (run_reg)
        begin
            pp_reg     <= PP_W'(a_limb) * PP_W'(b_limb);
            pp_sel_reg <= step_reg[1:0];
            if (pp_valid_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign res  = RES_W'(acc_reg >> SHIFT);

endmodule

### rtl/core/tsc_div.sv
module tsc_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_BITS = tsc_pkg::DIV_BITS;
    localparam int STEPS     = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W    = STEPS * STEP_BITS;
    localparam int CNT_W     = $clog2(STEPS);

    logic [WORK_W-1:0] work_reg;
    logic [WORK_W-1:0] work_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    // Restoring division: the dividend shifts out of the top of the work word
    // while quotient bits shift in at the bottom.
    always_comb
    begin
        logic [DEN_W:0] trial;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial     = {rem_next, work_next[WORK_W-1]};
            work_next = work_next << 1;
            if (trial >= {1'b0, dsr_reg})
            begin
                trial        = trial - {1'b0, dsr_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= WORK_W'(dividend);
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (run_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[NUM_W-1:0];

endmodule

### rtl/core/tsc_datapath.sv
module tsc_datapath #(
    parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEFAULT,
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tsc_pkg::cmd_t                       cmd,
    output tsc_pkg::status_t                    status,
    input  logic                                cfg_wr_en,
    input  logic [tsc_pkg::THRESH_W-1:0]        cfg_wr_data,
    input  logic signed [tsc_pkg::ANGLE_W-1:0]  angle,
    output logic signed [tsc_pkg::VALUE_W-1:0]  sine_value,
    output logic signed [tsc_pkg::VALUE_W-1:0]  cosine_value
);

    localparam int ANGLE_W = tsc_pkg::ANGLE_W;
    localparam int VALUE_W = tsc_pkg::VALUE_W;
    localparam int UP      = tsc_pkg::OUT_FRAC - FRAC_BITS;
    localparam int MAG_W   = FRAC_BITS + 3;
    localparam int X2_W    = FRAC_BITS + 6;
    localparam int TERM_W  = FRAC_BITS + 8;
    localparam int NUM_W   = FRAC_BITS + 13;
    localparam int SUM_W   = FRAC_BITS + 11;
    localparam int SAT_W   = SUM_W + UP;
    localparam int CMP_W   = TERM_W + UP;
    localparam int K_W     = $clog2(2 * MAX_TERMS + 3);
    localparam int D_W     = 2 * K_W;

    localparam int SH_UP = (FRAC_BITS >= tsc_pkg::ANGLE_FRAC) ?
                           FRAC_BITS - tsc_pkg::ANGLE_FRAC : 0;
    localparam int SH_DN = (FRAC_BITS >= tsc_pkg::ANGLE_FRAC) ?
                           0 : tsc_pkg::ANGLE_FRAC - FRAC_BITS;
    localparam int CV_W  = tsc_pkg::ANG_MAG_W + 1 + SH_UP;
    localparam logic [CV_W-1:0] CV_ROUND = (CV_W'(1) << SH_DN) >> 1;

    localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'(tsc_pkg::VALUE_MAX);
    localparam logic signed [SAT_W-1:0] OUT_MIN = SAT_W'(tsc_pkg::VALUE_MIN);

    logic [tsc_pkg::THRESH_W-1:0] thr_reg;
    logic signed [ANGLE_W-1:0]    ang_reg;
    logic [MAG_W-1:0]             xmag_reg;
    logic                         xneg_reg;
    logic [X2_W-1:0]              x2_reg;
    logic [TERM_W-1:0]            term_reg;
    logic                         term_neg_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic [K_W-1:0]               k_reg;
    logic [D_W-1:0]               div_reg;
    logic signed [VALUE_W-1:0]    sine_hold_reg;
    logic signed [VALUE_W-1:0]    sine_out_reg;
    logic signed [VALUE_W-1:0]    cosine_out_reg;

    logic signed [ANGLE_W-1:0]    ang_abs;
    logic [CV_W-1:0]              cv;
    logic [MAG_W-1:0]             xmag_next;
    logic [CMP_W-1:0]             term_scaled;
    logic signed [SUM_W-1:0]      term_ext;
    logic [TERM_W-1:0]            mul_a;
    logic [TERM_W-1:0]            mul_b;
    logic [NUM_W-1:0]             mul_res;
    logic [NUM_W-1:0]             quo;
    logic                         mul_done;
    logic                         div_done;

    function automatic logic signed [VALUE_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic signed [SAT_W-1:0] s;
        s = SAT_W'(v) <<< UP;
        priority if (s > OUT_MAX)
            return tsc_pkg::VALUE_MAX;
        else if (s < OUT_MIN)
            return tsc_pkg::VALUE_MIN;
        else
            return s[VALUE_W-1:0];
    endfunction

    // Angle magnitude moved from Q8.24 into the working format; a right shift
    // rounds half away from zero since it acts on the magnitude.
    always_comb
    begin
        ang_abs   = (ang_reg < 0) ? -ang_reg : ang_reg;
        cv        = ((CV_W'(ang_abs[tsc_pkg::ANG_MAG_W-1:0]) + CV_ROUND) >> SH_DN) << SH_UP;
        xmag_next = MAG_W'(cv);
    end

    assign term_scaled = CMP_W'(term_reg) << UP;
    assign term_ext    = $signed(SUM_W'(term_reg));

    assign mul_a = cmd.mul_x2_start ? TERM_W'(xmag_reg) : term_reg;
    assign mul_b = cmd.mul_x2_start ? TERM_W'(xmag_reg) : TERM_W'(x2_reg);

    tsc_mul #(
        .OP_W  (TERM_W),
        .SHIFT (FRAC_BITS),
        .RES_W (NUM_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_x2_start || cmd.term_accept),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    tsc_div #(
        .NUM_W (NUM_W),
        .DEN_W (D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mul_res),
        .divisor  (div_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        status.above      = ang_reg > tsc_pkg::TWO_PI_Q24;
        status.below      = ang_reg < -tsc_pkg::TWO_PI_Q24;
        status.term_small = term_scaled < CMP_W'(thr_reg);
        status.mul_done   = mul_done;
        status.div_done   = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tsc_pkg::THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_angle)
        begin
            ang_reg <= angle;
        end
        else if (cmd.reduce_sub)
        begin
            ang_reg <= ang_reg - tsc_pkg::TWO_PI_Q24;
        end
        else if (cmd.reduce_add)
        begin
            ang_reg <= ang_reg + tsc_pkg::TWO_PI_Q24;
        end

        if (cmd.convert)
        begin
            xmag_reg <= xmag_next;
            xneg_reg <= ang_reg < 0;
        end

        if (cmd.load_x2)
        begin
            x2_reg <= X2_W'(mul_res);
        end

        if (cmd.series_init)
        begin
            sum_reg <= '0;
            if (cmd.series_cos)
            begin
                term_reg     <= TERM_W'(1) << FRAC_BITS;
                term_neg_reg <= 1'b0;
                k_reg        <= K_W'(1);
            end
            else
            begin
                term_reg     <= TERM_W'(xmag_reg);
                term_neg_reg <= xneg_reg;
                k_reg        <= K_W'(2);
            end
        end
        else if (cmd.term_update)
        begin
            term_reg     <= TERM_W'(quo);
            term_neg_reg <= !term_neg_reg;
            k_reg        <= k_reg + K_W'(2);
        end
        else if (cmd.term_accept)
        begin
            sum_reg <= term_neg_reg ? sum_reg - term_ext : sum_reg + term_ext;
            div_reg <= D_W'(k_reg) * D_W'(k_reg + K_W'(1));
        end

        if (cmd.save_sine)
        begin
            sine_hold_reg <= saturate(sum_reg);
        end

        if (cmd.load_out)
        begin
            sine_out_reg   <= sine_hold_reg;
            cosine_out_reg <= saturate(sum_reg);
        end
    end

    assign sine_value   = sine_out_reg;
    assign cosine_value = cosine_out_reg;

endmodule

### rtl/core/tsc_ctrl.sv
module tsc_ctrl #(
    parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tsc_pkg::status_t status,
    output tsc_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b0000000001,
        ST_REDUCE     = 10'b0000000010,
        ST_CONVERT    = 10'b0000000100,
        ST_X2_START   = 10'b0000001000,
        ST_X2_WAIT    = 10'b0000010000,
        ST_CHECK      = 10'b0000100000,
        ST_MUL_WAIT   = 10'b0001000000,
        ST_DIV_WAIT   = 10'b0010000000,
        ST_SERIES_END = 10'b0100000000,
        ST_FINISH     = 10'b1000000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cos_pass_reg;
    logic             cos_pass_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_angle = 1'b1;
                    state_next     = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                priority if (status.above)
                    cmd.reduce_sub = 1'b1;
                else if (status.below)
                    cmd.reduce_add = 1'b1;
                else
                    state_next = ST_CONVERT;
            end
            ST_CONVERT:
            begin
                cmd.convert = 1'b1;
                state_next  = ST_X2_START;
            end
            ST_X2_START:
            begin
                cmd.mul_x2_start = 1'b1;
                state_next       = ST_X2_WAIT;
            end
            ST_X2_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.load_x2     = 1'b1;
                    cmd.series_init = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // The term that falls below the threshold is not added.
                if (status.term_small || (cnt_reg == CNT_W'(MAX_TERMS)))
                begin
                    state_next = ST_SERIES_END;
                end
                else
                begin
                    cmd.term_accept = 1'b1;
                    state_next      = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.term_update = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_SERIES_END:
            begin
                if (!cos_pass_reg)
                begin
                    cmd.save_sine   = 1'b1;
                    cmd.series_init = 1'b1;
                    cmd.series_cos  = 1'b1;
                    state_next      = ST_CHECK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        cos_pass_next  = cos_pass_reg;
        out_valid_next = out_valid_reg;
        if (cmd.series_init)
        begin
            cnt_next      = '0;
            cos_pass_next = cmd.series_cos;
        end
        else if (cmd.term_update)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cos_pass_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cos_pass_reg  <= cos_pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/taylor_sine_cosine.sv
// Channel     Direction  Payload                               Handshake
// angle_ch    in         angle, signed Q8.24 radians           valid / ready
// result_ch   out        sine_value, cosine_value, Q2.30       valid / ready
// cfg_wr      in         stop_threshold, 31-bit Q1.30          write enable, no wait
//
// One item is processed at a time. An angle needs up to 20 corrections by 2pi, and at
// most 2 * MAX_TERMS terms are summed over both series. Each term is set by the shared
// four-pass limb multiplier and the 4-bit-per-cycle divider, which runs
// S = ceil((FRAC_BITS + 13) / 4) steps per term.
// Reset clears the sequencer and the result valid flag and loads the threshold with 107.
// A new angle is taken while a finished item waits in the output register; while
// that register stays full the next item is held after its last term.
module taylor_sine_cosine #(
    parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEFAULT,
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tsc_pkg::THRESH_W-1:0]  cfg_wr_data,
    tsc_angle_if.sink                     angle_ch,
    tsc_result_if.source                  result_ch
);

    tsc_pkg::cmd_t    cmd;
    tsc_pkg::status_t status;

    tsc_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (angle_ch.valid),
        .in_ready  (angle_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tsc_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .angle        (angle_ch.angle),
        .sine_value   (result_ch.sine_value),
        .cosine_value (result_ch.cosine_value)
    );

`ifndef SYNTHESIS
    // Once an angle is taken, no other item enters until its result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        angle_ch.valid && angle_ch.ready |=> !angle_ch.ready)
        else $error("angle taken while an item is in flight");

    // A finished item never overwrites a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_ch.valid || result_ch.ready))
        else $error("pending result overwritten");

    // The multiplier and the divider are started one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.term_accept, cmd.mul_x2_start, cmd.div_start}))
        else $error("arithmetic units started together");

    // The divider only starts on a finished product.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_done && $past(cmd.term_accept, 6))
        else $error("divider started out of sequence");
`endif

endmodule

### tb/sv/taylor_sine_cosine_check.sv
module taylor_sine_cosine_check #(
    parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEFAULT,
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tsc_pkg::THRESH_W-1:0]  cfg_wr_data,
    tsc_angle_if                          angle_ch,
    tsc_result_if                         result_ch,
    output int                            mismatches,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [VALUE_W-1:0] sine;
        logic signed [VALUE_W-1:0] cosine;
    } trig_pair_t;

    logic [THRESH_W-1:0] threshold;
    trig_pair_t          expected_pairs[$];

    // Rounds half up when the working fraction bits are dropped from a*b.
    function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod + (128'd1 << (FRAC_BITS - 1));
        return prod[FRAC_BITS +: 64];
    endfunction

    function automatic logic signed [63:0] series_sum(logic [63:0] mag, bit neg,
                                                      logic [63:0] x2, int unsigned off,
                                                      logic [THRESH_W-1:0] thr);
        logic signed [63:0] acc;
        logic [63:0]        div;
        acc = 64'sd0;
        for (int j = 0; j < MAX_TERMS; j++)
        begin
            if ((mag << (30 - FRAC_BITS)) < 64'(thr))
                break;
            acc = neg ? acc - $signed(mag) : acc + $signed(mag);
            div = 64'((2 * j + 1 + off) * (2 * j + 2 + off));
            mag = mul_round(mag, x2) / div;
            neg = !neg;
        end
        return acc;
    endfunction

    function automatic logic signed [VALUE_W-1:0] to_q30(logic signed [63:0] v);
        logic signed [63:0] q;
        q = v <<< (30 - FRAC_BITS);
        if (q > VALUE_MAX)
            return VALUE_MAX;
        if (q < VALUE_MIN)
            return VALUE_MIN;
        return q[VALUE_W-1:0];
    endfunction

    function automatic trig_pair_t series_sine_cosine(logic signed [ANGLE_W-1:0] ang,
                                                      logic [THRESH_W-1:0] thr);
        trig_pair_t         pair;
        logic signed [63:0] a;
        logic signed [63:0] two_pi;
        logic [63:0]        mag;
        logic [63:0]        x2;
        bit                 neg;
        int                 sh;
        a = ang;
        two_pi = TWO_PI_Q24;
        // Reduction only acts strictly beyond 2pi, so +-2pi itself is kept.
        while (a > two_pi)
            a = a - two_pi;
        while (a < -two_pi)
            a = a + two_pi;
        neg = (a < 0);
        mag = neg ? 64'(-a) : 64'(a);
        sh = 24 - FRAC_BITS;
        if (sh <= 0)
            mag = mag << (-sh);
        else
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
        x2 = mul_round(mag, mag);
        pair.angle = ang;
        pair.sine = to_q30(series_sum(mag, neg, x2, 1, thr));
        pair.cosine = to_q30(series_sum(64'd1 << FRAC_BITS, 1'b0, x2, 0, thr));
        return pair;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        trig_pair_t want;
        if (!rst_n)
        begin
            threshold <= THRESH_RESET;
            expected_pairs.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                threshold <= cfg_wr_data;
            // Results are taken before the new angle so a stray result is never
            // matched against an item accepted on the same edge.
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    report_mismatch($sformatf("result with no angle outstanding: sin %0d cos %0d",
                                              result_ch.sine_value, result_ch.cosine_value));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (result_ch.sine_value !== want.sine)
                        report_mismatch($sformatf("angle %0d: sine_value %0d, expected %0d",
                                                  want.angle, result_ch.sine_value, want.sine));
                    if (result_ch.cosine_value !== want.cosine)
                        report_mismatch($sformatf("angle %0d: cosine_value %0d, expected %0d",
                                                  want.angle, result_ch.cosine_value,
                                                  want.cosine));
                end
            end
            if (angle_ch.valid && angle_ch.ready)
                expected_pairs.push_back(series_sine_cosine(angle_ch.angle, threshold));
            pending <= expected_pairs.size();
        end
    end

endmodule

### tb/sv/taylor_sine_cosine_tb.sv
module taylor_sine_cosine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 16_000_000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          HOLD_CYCLES   = 6000;
    localparam int          PI_Q24        = 52707179;
    localparam int          HALF_PI_Q24   = 26353589;

    localparam int DIRECTED_ANGLES[17] = '{
        0, 1, -1, 32'sh7FFFFFFF, 32'sh80000000,
        105414357, -105414357, 105414358, -105414358, 105414356,
        PI_Q24, -PI_Q24, HALF_PI_Q24, 16777216, -16777216,
        32'sh55555555, 32'shAAAAAAAA
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THRESH_W-1:0] cfg_wr_data;
    int                  mismatches;
    int                  pending;
    int unsigned         cycle_count = 0;
    bit                  hold_off = 1'b0;
    bit                  pressure_go = 1'b0;

    tsc_angle_if  angle_ch ();
    tsc_result_if result_ch ();

    taylor_sine_cosine i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .angle_ch    (angle_ch),
        .result_ch   (result_ch)
    );

    taylor_sine_cosine_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .angle_ch    (angle_ch),
        .result_ch   (result_ch),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: runs of cycles with a fixed chance of being ready.
    initial
    begin : result_stall
        int ready_pct;
        int span;
        result_ch.ready <= 1'b0;
        forever
        begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 50;
                default: ready_pct = 12;
            endcase
            span = $urandom_range(10, 300);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_off)
                    result_ch.ready <= 1'b0;
                else
                    result_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // One long hold on the result side so the block fills up and stalls its input.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int two_pi;
        int k;
        two_pi = int'(TWO_PI_Q24);
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2, 3: return int'($urandom_range(0, 2 * two_pi)) - two_pi;
            4: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
            5:
            begin
                k = int'($urandom_range(0, 40)) - 20;
                return k * two_pi + int'($urandom_range(0, 8)) - 4;
            end
            6:
            begin
                k = ($urandom_range(0, 1) != 0) ? PI_Q24 : HALF_PI_Q24;
                if ($urandom_range(0, 1) != 0)
                    k = -k;
                return k + int'($urandom_range(0, 64)) - 32;
            end
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll < 8)
            return 0;
        else if (roll < 14)
            return $urandom_range(1, 30);
        else
            return $urandom_range(100, 1200);
    endfunction

    // Holds the angle until the block takes it; returns on the accepting edge.
    task automatic offer_angle(logic signed [ANGLE_W-1:0] a);
        angle_ch.valid <= 1'b1;
        angle_ch.angle <= a;
        @(posedge clk);
        while (!angle_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        wait (pending == 0);
    endtask

    task automatic set_threshold(logic [THRESH_W-1:0] value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_directed(int first, int count);
        for (int k = first; k < first + count; k++)
            offer_angle(DIRECTED_ANGLES[k]);
        angle_ch.valid <= 1'b0;
    endtask

    task automatic send_random(int count);
        int burst;
        int gap;
        burst = 0;
        for (int k = 0; k < count; k++)
        begin
            offer_angle(pick_angle());
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = pick_gap();
                if (gap > 0)
                begin
                    angle_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
                burst--;
        end
        angle_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        angle_ch.valid <= 1'b0;
        angle_ch.angle <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: zero, +-1 LSB, range extremes, 2pi exact and one LSB either side, pi, pi/2, +-1.
        send_directed(0, 17);

        // Zero threshold sums every term; a threshold of 1.0 stops early.
        set_threshold('0);
        offer_angle(TWO_PI_Q24);
        offer_angle(HALF_PI_Q24);
        offer_angle(-1);
        offer_angle(78060767);
        angle_ch.valid <= 1'b0;
        set_threshold(31'h4000_0000);
        offer_angle(TWO_PI_Q24);
        offer_angle(0);
        offer_angle(-PI_Q24);
        offer_angle(1);
        angle_ch.valid <= 1'b0;

        set_threshold(THRESH_RESET);
        send_random(450);
        set_threshold('0);
        send_random(80);
        set_threshold(31'd1);
        pressure_go <= 1'b1;
        send_random(300);
        set_threshold(THRESH_W'($urandom_range(2, 4095)));
        send_random(300);
        set_threshold(THRESH_W'($urandom_range(0, 32'h4000_0000)));
        send_random(150);
        set_threshold(31'h4000_0000);
        send_random(100);
        set_threshold(THRESH_W'($urandom_range(0, 32'h4000_0000)));
        send_random(150);
        set_threshold(THRESH_W'($urandom_range(100, 2000)));
        send_random(200);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/tsc_pkg.sv
rtl/core/tsc_angle_if.sv
rtl/core/tsc_result_if.sv
rtl/core/tsc_mul.sv
rtl/core/tsc_div.sv
rtl/core/tsc_datapath.sv
rtl/core/tsc_ctrl.sv
rtl/core/taylor_sine_cosine.sv
tb/sv/taylor_sine_cosine_check.sv
tb/sv/taylor_sine_cosine_tb.sv
